### src/karf_pkg.sv
// Shared types, constants and helper functions of the angle/rate Kalman filter.
// Holds the micro-program run by the sequencer in the top level.
// Depends on nothing.
`default_nettype none

package karf_pkg;

    // Fixed initial covariance, Q24.40
    localparam logic [63:0] COV_AA_INIT = 64'd8322203511;
    localparam logic [63:0] COV_AR_INIT = 64'd765260093;
    localparam logic [63:0] COV_RR_INIT = 64'd109951163;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANGLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RATE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 8'd3;

    // Division: magnitude (up to 2^63) times 2^40 needs 104 bits
    localparam int DIV_BITS = 104;

    typedef enum logic [3:0] {
        OP_INIT,   // load initial value when restarting or not yet primed
        OP_LD,     // load from input or configuration
        OP_MUL,    // rounded, shifted, saturated product
        OP_DIV,    // (a * 2^40) / b
        OP_ADD,    // saturating add
        OP_SUB,    // saturating a - b
        OP_NEG,    // saturating negate
        OP_FLR,    // floor at one LSB
        OP_SAT32,  // saturate to 32 bits
        OP_END     // hand the result to the output register
    } t_op;

    typedef enum logic [4:0] {
        R_ANG, R_RAT, R_PAA, R_PAR, R_PRA, R_PRR,
        R_DT, R_DT20, R_DT2, R_DT3, R_DT4, R_PN, R_MN, R_MEAS,
        R_Q00, R_Q01, R_Q11, R_FP00, R_FP01,
        R_P00, R_P01, R_P10, R_P11, R_S, R_K0, R_K1, R_Y, R_T0, R_T1
    } t_reg;

    typedef enum logic [3:0] {
        LS_NONE, LS_ANG0, LS_RAT0, LS_CAA, LS_CAR, LS_CRR,
        LS_DT, LS_DT20, LS_DT2, LS_PN, LS_MN, LS_MEAS
    } t_lsrc;

    typedef struct packed {
        t_op        op;
        t_reg       dst;
        t_reg       a;
        t_reg       b;
        logic [5:0] sh;
        t_lsrc      ls;
    } t_instr;

    typedef enum logic [1:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT
    } t_state;

    typedef enum logic [1:0] {
        MS_IDLE, MS_PP, MS_RND, MS_SAT
    } t_mstate;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PROG_LAST = 6'd52;

    function automatic t_instr mk(t_op op, t_reg dst, t_reg a, t_reg b,
                                  logic [5:0] sh, t_lsrc ls);
        t_instr i;
        i.op  = op;
        i.dst = dst;
        i.a   = a;
        i.b   = b;
        i.sh  = sh;
        i.ls  = ls;
        return i;
    endfunction

    function automatic t_instr ld(t_op op, t_reg dst, t_lsrc ls);
        return mk(op, dst, R_T0, R_T0, 6'd0, ls);
    endfunction

    function automatic t_instr ar(t_op op, t_reg dst, t_reg a, t_reg b, logic [5:0] sh);
        return mk(op, dst, a, b, sh, LS_NONE);
    endfunction

    // Micro-program of one filter update
    function automatic t_instr prog(logic [PC_W-1:0] pc);
        t_instr i;
        case (pc)
            6'd0:  i = ld(OP_INIT, R_ANG, LS_ANG0);
            6'd1:  i = ld(OP_INIT, R_RAT, LS_RAT0);
            6'd2:  i = ld(OP_INIT, R_PAA, LS_CAA);
            6'd3:  i = ld(OP_INIT, R_PAR, LS_CAR);
            6'd4:  i = ld(OP_INIT, R_PRA, LS_CAR);
            6'd5:  i = ld(OP_INIT, R_PRR, LS_CRR);
            6'd6:  i = ld(OP_LD, R_DT, LS_DT);
            6'd7:  i = ld(OP_LD, R_DT20, LS_DT20);
            6'd8:  i = ld(OP_LD, R_DT2, LS_DT2);
            6'd9:  i = ld(OP_LD, R_PN, LS_PN);
            6'd10: i = ld(OP_LD, R_MN, LS_MN);
            6'd11: i = ld(OP_LD, R_MEAS, LS_MEAS);
            6'd12: i = ar(OP_MUL, R_DT3, R_DT2, R_DT20, 6'd20);
            6'd13: i = ar(OP_MUL, R_DT4, R_DT2, R_DT2, 6'd40);
            6'd14: i = ar(OP_MUL, R_Q00, R_PN, R_DT4, 6'd42);
            6'd15: i = ar(OP_MUL, R_Q01, R_PN, R_DT3, 6'd41);
            6'd16: i = ar(OP_MUL, R_Q11, R_PN, R_DT2, 6'd40);
            6'd17: i = ar(OP_MUL, R_T0, R_PRA, R_DT, 6'd40);
            6'd18: i = ar(OP_ADD, R_FP00, R_PAA, R_T0, 6'd0);
            6'd19: i = ar(OP_MUL, R_T0, R_PRR, R_DT, 6'd40);
            6'd20: i = ar(OP_ADD, R_FP01, R_PAR, R_T0, 6'd0);
            6'd21: i = ar(OP_MUL, R_T0, R_FP01, R_DT, 6'd40);
            6'd22: i = ar(OP_ADD, R_T0, R_FP00, R_T0, 6'd0);
            6'd23: i = ar(OP_ADD, R_P00, R_T0, R_Q00, 6'd0);
            6'd24: i = ar(OP_ADD, R_P01, R_FP01, R_Q01, 6'd0);
            6'd25: i = ar(OP_MUL, R_T0, R_PRR, R_DT, 6'd40);
            6'd26: i = ar(OP_ADD, R_T0, R_PRA, R_T0, 6'd0);
            6'd27: i = ar(OP_ADD, R_P10, R_T0, R_Q01, 6'd0);
            6'd28: i = ar(OP_ADD, R_P11, R_PRR, R_Q11, 6'd0);
            6'd29: i = ar(OP_ADD, R_S, R_P11, R_MN, 6'd0);
            6'd30: i = ar(OP_FLR, R_S, R_S, R_S, 6'd0);
            6'd31: i = ar(OP_DIV, R_K0, R_P01, R_S, 6'd0);
            6'd32: i = ar(OP_DIV, R_K1, R_P11, R_S, 6'd0);
            6'd33: i = ar(OP_SUB, R_Y, R_MEAS, R_RAT, 6'd0);
            6'd34: i = ar(OP_MUL, R_T0, R_RAT, R_DT20, 6'd20);
            6'd35: i = ar(OP_ADD, R_T0, R_ANG, R_T0, 6'd0);
            6'd36: i = ar(OP_MUL, R_T1, R_K0, R_Y, 6'd40);
            6'd37: i = ar(OP_ADD, R_T0, R_T0, R_T1, 6'd0);
            6'd38: i = ar(OP_MUL, R_T1, R_K1, R_Y, 6'd40);
            6'd39: i = ar(OP_ADD, R_T1, R_RAT, R_T1, 6'd0);
            6'd40: i = ar(OP_SAT32, R_ANG, R_T0, R_T0, 6'd0);
            6'd41: i = ar(OP_SAT32, R_RAT, R_T1, R_T1, 6'd0);
            6'd42: i = ar(OP_MUL, R_T0, R_K0, R_P10, 6'd40);
            6'd43: i = ar(OP_SUB, R_PAA, R_P00, R_T0, 6'd0);
            6'd44: i = ar(OP_NEG, R_T0, R_K0, R_K0, 6'd0);
            6'd45: i = ar(OP_MUL, R_T0, R_T0, R_P11, 6'd40);
            6'd46: i = ar(OP_ADD, R_PAR, R_P01, R_T0, 6'd0);
            6'd47: i = ar(OP_NEG, R_T1, R_K1, R_K1, 6'd0);
            6'd48: i = ar(OP_MUL, R_T0, R_T1, R_P10, 6'd40);
            6'd49: i = ar(OP_ADD, R_PRA, R_P10, R_T0, 6'd0);
            6'd50: i = ar(OP_MUL, R_T0, R_T1, R_P11, 6'd40);
            6'd51: i = ar(OP_ADD, R_PRR, R_P11, R_T0, 6'd0);
            default: i = ar(OP_END, R_T0, R_T0, R_T0, 6'd0);
        endcase
        return i;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    function automatic logic [63:0] neg_sat(logic [63:0] a);
        if (a == S64_MIN) return S64_MAX;
        return -a;
    endfunction

    function automatic logic [63:0] sat32(logic [63:0] a);
        if ($signed(a) > 64'sd2147483647) return 64'd2147483647;
        if ($signed(a) < -64'sd2147483648) return {{32{1'b1}}, 32'h8000_0000};
        return a;
    endfunction

    function automatic logic [63:0] mag64(logic [63:0] a);
        return a[63] ? -a : a;
    endfunction

endpackage

`default_nettype wire

### src/karf_mul.sv
// Iterative signed multiplier: 64x64 through one 32x32 multiplier over four
// partial products, then round half away from zero, shift and saturate.
// Depends on karf_pkg.
`default_nettype none

module karf_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    input  wire logic [5:0]  i_sh,
    output logic             o_done,
    output logic [63:0]      o_result
);
    import karf_pkg::*;

    t_mstate      r_st;
    logic [1:0]   r_cnt;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;
    logic [63:0]  r_res;

    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_prod;
    logic [127:0] w_part;
    logic [127:0] w_rnd;
    logic [63:0]  w_sat;

    // Select one partial product per cycle
    always_comb begin
        w_pa   = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
        w_pb   = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
        w_prod = 64'(w_pa) * 64'(w_pb);
        case (r_cnt)
            2'd0:    w_part = {64'd0, w_prod};
            2'd3:    w_part = {w_prod, 64'd0};
            default: w_part = {32'd0, w_prod, 32'd0};
        endcase
        w_rnd = (r_acc + (128'd1 << (r_sh - 6'd1))) >> r_sh;
    end

    // Saturate the shifted magnitude to signed 64 bits
    always_comb begin
        if (r_neg) begin
            if ((|r_acc[127:64]) || (r_acc[63:0] > S64_MIN)) w_sat = S64_MIN;
            else                                             w_sat = -r_acc[63:0];
        end else begin
            if (|r_acc[127:63]) w_sat = S64_MAX;
            else                w_sat = r_acc[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= MS_IDLE;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                MS_IDLE: begin
                    if (i_start) begin
                        r_ma  <= mag64(i_a);
                        r_mb  <= mag64(i_b);
                        r_neg <= i_a[63] ^ i_b[63];
                        r_sh  <= i_sh;
                        r_acc <= '0;
                        r_cnt <= 2'd0;
                        r_st  <= MS_PP;
                    end
                end
                MS_PP: begin
                    r_acc <= r_acc + w_part;
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) r_st <= MS_RND;
                end
                MS_RND: begin
                    r_acc <= w_rnd;
                    r_st  <= MS_SAT;
                end
                MS_SAT: begin
                    r_res  <= w_sat;
                    r_done <= 1'b1;
                    r_st   <= MS_IDLE;
                end
                default: r_st <= MS_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

### src/karf_div.sv
// Restoring divider: (num * 2^40) / den, one quotient bit per cycle,
// truncated toward zero and saturated to signed 64 bits. den is at least 1.
// Depends on karf_pkg.
`default_nettype none

module karf_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_result
);
    import karf_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_BITS-1:0] r_num;
    logic [63:0]         r_den;
    logic [63:0]         r_rem;
    logic [63:0]         r_q;
    logic                r_ovf;
    logic                r_neg;
    logic                r_fin;
    logic                r_done;
    logic [63:0]         r_res;

    logic [64:0] w_rem;
    logic        w_ge;
    logic [64:0] w_diff;
    logic [63:0] w_sat;

    // One restoring step
    always_comb begin
        w_rem  = {r_rem, r_num[DIV_BITS-1]};
        w_ge   = w_rem >= {1'b0, r_den};
        w_diff = w_rem - {1'b0, r_den};
    end

    // Saturate the quotient magnitude
    always_comb begin
        if (r_neg) begin
            if (r_ovf || (r_q > S64_MIN)) w_sat = S64_MIN;
            else                          w_sat = -r_q;
        end else begin
            if (r_ovf || r_q[63]) w_sat = S64_MAX;
            else                  w_sat = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start && !r_busy) begin
                r_num  <= {mag64(i_num), 40'd0};
                r_den  <= i_den;
                r_neg  <= i_num[63];
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? w_diff[63:0] : w_rem[63:0];
                r_q   <= {r_q[62:0], w_ge};
                r_ovf <= r_ovf | r_q[63];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_res  <= w_sat;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

### src/kalman_angle_rate_filter_core.sv
// Top level of the two-state angle/rate Kalman filter: sequencer, operand
// memory, configuration registers and stream ports.
// Depends on karf_pkg, karf_mul and karf_div.
`default_nettype none

// One update runs from the input transaction to the output as a 53-step
// micro-program over a 32-entry operand memory, each step passing through a
// fetch state and then its execution. The two gain divisions (fetch, start,
// 104 quotient bits at one per cycle, saturate, hand over) and the sixteen
// products through the single 32x32 multiplier wait on their unit; the other
// 35 steps finish in their execution state. The input is not ready while an
// update runs. The result waits in an output register, so the next item is
// taken as soon as the sequencer is idle; a result stalls at its last step
// only while the previous one is still untaken. The state after reset is
// zero estimates and the fixed initial covariance; a restart flag reloads
// the estimates from the init registers and the covariance from its fixed
// initial values first.

module kalman_angle_rate_filter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [karf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [62:0]                   i_cfg_data,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [55:0]                   i_s_axis_tdata,  // measured_rate[31:0], time_step[51:32]
    input  wire logic [0:0]                    i_s_axis_tuser,  // restart[0]
    // output stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [63:0]                        o_m_axis_tdata   // angle_out[31:0], rate_out[63:32]
);
    import karf_pkg::*;

    // configuration
    logic [31:0] r_init_angle, r_init_rate;
    logic [62:0] r_pn, r_mn;

    // latched transaction
    logic        r_restart;
    logic [31:0] r_meas;
    logic [19:0] r_dt;
    logic        r_primed;

    // sequencer
    t_state         r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [63:0]    r_mem [32];
    logic [63:0]    r_opa, r_opb;
    logic [31:0]    r_ang_hold, r_rat_hold;
    logic           r_ov, n_ov;
    logic [63:0]    r_out;

    t_instr      w_ins;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_wr_en;
    logic [63:0] w_wr_data;
    logic [63:0] w_ls_val;
    logic        w_mul_start, w_div_start;
    logic        w_mul_done, w_div_done;
    logic [63:0] w_mul_res, w_div_res;
    logic        w_load_out;

    assign w_ins     = prog(r_pc);
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = r_ov && i_m_axis_tready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_angle <= '0;
            r_init_rate  <= '0;
            r_pn         <= '0;
            r_mn         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INIT_ANGLE: r_init_angle <= i_cfg_data[31:0];
                CFG_INIT_RATE:  r_init_rate  <= i_cfg_data[31:0];
                CFG_PROC_NOISE: r_pn         <= i_cfg_data;
                CFG_MEAS_NOISE: r_mn         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Select the value of a load step
    always_comb begin
        case (w_ins.ls)
            LS_ANG0: w_ls_val = r_restart ? {{32{r_init_angle[31]}}, r_init_angle} : 64'd0;
            LS_RAT0: w_ls_val = r_restart ? {{32{r_init_rate[31]}}, r_init_rate} : 64'd0;
            LS_CAA:  w_ls_val = COV_AA_INIT;
            LS_CAR:  w_ls_val = COV_AR_INIT;
            LS_CRR:  w_ls_val = COV_RR_INIT;
            LS_DT:   w_ls_val = {24'd0, r_dt, 20'd0};
            LS_DT20: w_ls_val = {44'd0, r_dt};
            LS_DT2:  w_ls_val = {24'd0, 40'(r_dt) * 40'(r_dt)};
            LS_PN:   w_ls_val = {1'b0, r_pn};
            LS_MN:   w_ls_val = {1'b0, r_mn};
            LS_MEAS: w_ls_val = {{32{r_meas[31]}}, r_meas};
            default: w_ls_val = 64'd0;
        endcase
    end

    // Sequence the micro-program
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_ov        = r_ov && !w_out_acc;
        w_wr_en     = 1'b0;
        w_wr_data   = 64'd0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_FETCH;
                    n_pc    = '0;
                end
            end
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = ST_FETCH;
                n_pc    = r_pc + PC_W'(1);
                case (w_ins.op)
                    OP_INIT: begin
                        w_wr_en   = r_restart || !r_primed;
                        w_wr_data = w_ls_val;
                    end
                    OP_LD: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = w_ls_val;
                    end
                    OP_ADD: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = sat_add(r_opa, r_opb);
                    end
                    OP_SUB: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = sat_add(r_opa, neg_sat(r_opb));
                    end
                    OP_NEG: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = neg_sat(r_opa);
                    end
                    OP_FLR: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = ($signed(r_opa) < 64'sd1) ? 64'd1 : r_opa;
                    end
                    OP_SAT32: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = sat32(r_opa);
                    end
                    OP_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = ST_WAIT;
                        n_pc        = r_pc;
                    end
                    OP_DIV: begin
                        w_div_start = 1'b1;
                        n_state     = ST_WAIT;
                        n_pc        = r_pc;
                    end
                    default: begin
                        // last step: hand over once the output register is free
                        if (!r_ov || w_out_acc) begin
                            w_load_out = 1'b1;
                            n_ov       = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_state = ST_EXEC;
                        end
                        n_pc = r_pc;
                    end
                endcase
            end
            ST_WAIT: begin
                if (w_mul_done || w_div_done) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_mul_done ? w_mul_res : w_div_res;
                    n_pc      = r_pc + PC_W'(1);
                    n_state   = ST_FETCH;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_ov     <= 1'b0;
            r_primed <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_ov    <= n_ov;
            if (w_load_out) r_primed <= 1'b1;
        end
    end

    // Latch the input transaction
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_restart <= i_s_axis_tuser[0];
            r_meas    <= i_s_axis_tdata[31:0];
            r_dt      <= i_s_axis_tdata[51:32];
        end
    end

    // Operand memory: one write port, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_ins.dst] <= w_wr_data;
        if (r_state == ST_FETCH) begin
            r_opa <= r_mem[w_ins.a];
            r_opb <= r_mem[w_ins.b];
        end
    end

    // Keep the saturated estimates and load the output register
    always_ff @(posedge i_clk) begin
        if (w_wr_en && w_ins.op == OP_SAT32) begin
            if (w_ins.dst == R_ANG) r_ang_hold <= w_wr_data[31:0];
            else                    r_rat_hold <= w_wr_data[31:0];
        end
        if (w_load_out) r_out <= {r_rat_hold, r_ang_hold};
    end

    karf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (r_opa),
        .i_b      (r_opb),
        .i_sh     (w_ins.sh),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    karf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (r_opa),
        .i_den    (r_opb),
        .o_done   (w_div_done),
        .o_result (w_div_res)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_done || w_div_done) |-> r_state == ST_WAIT)
        else $error("arithmetic unit finished outside a wait step");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_pc <= PROG_LAST)
        else $error("program counter ran past the last step");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_FETCH && r_pc == '0))
        else $error("accepted transaction did not start the program");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the angle/rate Kalman filter core.
// Predicts every update in fixed point and checks each output transaction.
// Depends on karf_pkg and kalman_angle_rate_filter_core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import karf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] rate;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [62:0] i_cfg_data = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [55:0] i_s_axis_tdata = '0;
    logic [0:0] i_s_axis_tuser = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;

    kalman_angle_rate_filter_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [63:0] init_angle_q, init_rate_q, proc_noise_q, meas_noise_q;
    logic signed [63:0] angle_q, rate_q, p_aa, p_ar, p_ra, p_rr;
    t_estimate estimate_queue[$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

    function automatic logic signed [63:0] clamp64(logic signed [129:0] v);
        if (v > $signed({66'd0, SMAX})) return SMAX;
        if (v < -$signed(130'sd1 <<< 63)) return SMIN;
        return v[63:0];
    endfunction

    // Product shifted right, rounded half away from zero, saturated
    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                  logic signed [63:0] b, int sh);
        logic [129:0] ma, mb, m;
        logic neg;
        ma = a < 0 ? -$signed({{66{a[63]}}, a}) : {66'd0, a};
        mb = b < 0 ? -$signed({{66{b[63]}}, b}) : {66'd0, b};
        neg = (a < 0) != (b < 0);
        m = (ma * mb + (130'd1 << (sh - 1))) >> sh;
        return clamp64(neg ? -$signed(m) : $signed(m));
    endfunction

    function automatic logic signed [63:0] fx_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
        return clamp64($signed({{66{a[63]}}, a}) + $signed({{66{b[63]}}, b}));
    endfunction

    function automatic logic signed [63:0] fx_neg(logic signed [63:0] a);
        return a == SMIN ? SMAX : -a;
    endfunction

    // Gain quotient (num * 2^40) / den, truncated toward zero
    function automatic logic signed [63:0] fx_div(logic signed [63:0] num,
                                                  logic signed [63:0] den);
        logic [129:0] m, q;
        m = num < 0 ? -$signed({{66{num[63]}}, num}) : {66'd0, num};
        q = (m << 40) / {66'd0, den};
        return clamp64(num < 0 ? -$signed(q) : $signed(q));
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic load_initial();
        angle_q = init_angle_q;
        rate_q = init_rate_q;
        p_aa = COV_AA_INIT;
        p_ar = COV_AR_INIT;
        p_ra = COV_AR_INIT;
        p_rr = COV_RR_INIT;
    endtask

    // Advance the predicted filter by one measurement
    task automatic predict_update(logic restart, logic [31:0] meas, logic [19:0] step);
        logic signed [63:0] dt, dt20, dt2, dt3, dt4, q00, q01, q11;
        logic signed [63:0] fp00, fp01, p00, p01, p10, p11, s, k0, k1, y, ang, rat;
        t_estimate e;
        dt20 = {44'd0, step};
        dt = dt20 <<< 20;
        dt2 = dt20 * dt20;
        dt3 = fx_mul(dt2, dt20, 20);
        dt4 = fx_mul(dt2, dt2, 40);
        if (restart) load_initial();
        q00 = fx_mul(proc_noise_q, dt4, 42);
        q01 = fx_mul(proc_noise_q, dt3, 41);
        q11 = fx_mul(proc_noise_q, dt2, 40);
        fp00 = fx_add(p_aa, fx_mul(p_ra, dt, 40));
        fp01 = fx_add(p_ar, fx_mul(p_rr, dt, 40));
        p00 = fx_add(fx_add(fp00, fx_mul(fp01, dt, 40)), q00);
        p01 = fx_add(fp01, q01);
        p10 = fx_add(fx_add(p_ra, fx_mul(p_rr, dt, 40)), q01);
        p11 = fx_add(p_rr, q11);
        s = fx_add(p11, meas_noise_q);
        if (s < 1) s = 1;
        k0 = fx_div(p01, s);
        k1 = fx_div(p11, s);
        y = $signed({{32{meas[31]}}, meas}) - rate_q;
        ang = fx_add(angle_q, fx_mul(rate_q, dt20, 20));
        ang = fx_add(ang, fx_mul(k0, y, 40));
        rat = fx_add(rate_q, fx_mul(k1, y, 40));
        angle_q = clamp32(ang);
        rate_q = clamp32(rat);
        p_aa = fx_add(p00, fx_neg(fx_mul(k0, p10, 40)));
        p_ar = fx_add(p01, fx_mul(fx_neg(k0), p11, 40));
        p_ra = fx_add(p10, fx_mul(fx_neg(k1), p10, 40));
        p_rr = fx_add(p11, fx_mul(fx_neg(k1), p11, 40));
        e.angle = angle_q[31:0];
        e.rate = rate_q[31:0];
        estimate_queue.push_back(e);
    endtask

    // Write one register while the core is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INIT_ANGLE: init_angle_q = $signed({{32{value[31]}}, value[31:0]});
            CFG_INIT_RATE:  init_rate_q = $signed({{32{value[31]}}, value[31:0]});
            CFG_PROC_NOISE: proc_noise_q = {1'b0, value};
            CFG_MEAS_NOISE: meas_noise_q = {1'b0, value};
            default: ;
        endcase
    endtask

    // Send one measurement transaction; called at a falling edge
    task automatic send_item(logic restart, logic [31:0] meas, logic [19:0] step);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {4'd0, step, meas};
        i_s_axis_tuser <= restart;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_update(restart, meas, step);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (estimate_queue.size() != 0) @(negedge i_clk);
        repeat (500) @(negedge i_clk);
    endtask

    task automatic set_config(logic [31:0] a0, logic [31:0] r0, logic [62:0] pn,
                              logic [62:0] mn);
        drain();
        write_reg(CFG_INIT_ANGLE, {31'd0, a0});
        write_reg(CFG_INIT_RATE, {31'd0, r0});
        write_reg(CFG_PROC_NOISE, pn);
        write_reg(CFG_MEAS_NOISE, mn);
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    // Field extremes, zero noise, restarts and saturation
    task automatic test_directed();
        send_item(1'b0, 32'd0, 20'd0);
        send_item(1'b0, 32'h7FFF_FFFF, 20'hFFFFF);
        send_item(1'b0, 32'h8000_0000, 20'hFFFFF);
        send_item(1'b1, 32'h0001_0000, 20'h00400);
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF,
                   63'h7FFF_FFFF_FFFF_FFFF);
        send_item(1'b1, 32'h8000_0000, 20'hFFFFF);
        send_item(1'b0, 32'h7FFF_FFFF, 20'hFFFFF);
        send_item(1'b0, 32'h8000_0000, 20'h00001);
        set_config(32'h8000_0000, 32'h8000_0000, 63'd0, 63'd0);
        send_item(1'b1, 32'h7FFF_FFFF, 20'hFFFFF);
        send_item(1'b0, 32'h7FFF_FFFF, 20'hFFFFF);
        send_item(1'b0, 32'hFFFF_FFFF, 20'h80000);
        // Drive the covariance hard so the variance floor and clamps engage
        set_config(32'd0, 32'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0);
        send_item(1'b1, 32'h1234_5678, 20'hFFFFF);
        repeat (6) send_item(1'b0, $urandom, 20'hFFFFF);
        // Hold off until every estimate has come back
        drain();
        send_item(1'b1, 32'h0000_0001, 20'h00001);
    endtask

    // Long runs of updates with occasional restarts
    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0)
                set_config($urandom, $urandom_range(1) ? $urandom : $urandom_range(65536),
                           $urandom_range(1) ? rand63() : rand63() >> $urandom_range(62),
                           $urandom_range(1) ? rand63() : rand63() >> $urandom_range(62));
            send_item($urandom_range(15) == 0, $urandom_range(1) ? $urandom :
                      $urandom_range(200000) - 100000,
                      20'($urandom_range(3) == 0 ? $urandom : $urandom_range(20000)));
        end
    endtask

    // Check each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_estimate e;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (estimate_queue.size() == 0) begin
                $error("unexpected output %h", o_m_axis_tdata);
                error_count++;
            end else begin
                e = estimate_queue.pop_front();
                if (o_m_axis_tdata[31:0] !== e.angle) begin
                    $error("angle_out exp %h got %h", e.angle, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[63:32] !== e.rate) begin
                    $error("rate_out exp %h got %h", e.rate, o_m_axis_tdata[63:32]);
                    error_count++;
                end
            end
        end
    end

    // Random backpressure on the output
    always @(negedge i_clk)
        i_m_axis_tready <= $urandom_range(99) >= recv_idle_pct;

    // Watchdog over cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        init_angle_q = 0;
        init_rate_q = 0;
        proc_noise_q = 0;
        meas_noise_q = 0;
        load_initial();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_pct = 11;
        recv_idle_pct = 47;
        test_directed();
        test_random(600);
        send_idle_pct = 47;
        recv_idle_pct = 11;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(480);
        drain();
        if (error_count == 0 && estimate_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

### kalman_angle_rate_filter_core.f
src/karf_pkg.sv
src/karf_mul.sv
src/karf_div.sv
src/kalman_angle_rate_filter_core.sv
bench/testbench.sv
